// ===== rtl/rth_pkg.sv =====
package rth_pkg;

  // Coordinate format: signed, COORD_BITS wide (Q4.12 by default).
  localparam int COORD_BITS = 16;
  localparam int DIF_W      = COORD_BITS + 1;   // vector difference
  localparam int PRD_W      = 2 * DIF_W;        // difference times difference
  localparam int CRS_W      = PRD_W + 1;        // cross product component
  localparam int DPR_W      = DIF_W + CRS_W;    // difference times cross component
  localparam int SUM_W      = DPR_W + 2;        // three-term dot product
  localparam int VTX_W      = 3 * COORD_BITS;   // packed vertex register
  localparam int THR_W      = 40;               // determinant threshold
  localparam int APB_DW     = 64;
  localparam int NUM_REGS   = 5;
  localparam int APB_AW     = $clog2(NUM_REGS * 8);

  // Register pipeline stages between the input and the decision logic.
  localparam int PIPE_DEPTH = 5;

  // 0.00001 at Q.36
  localparam logic [THR_W-1:0] DET_THR_RST = THR_W'(687195);

  localparam logic [APB_AW-4:0] REG_VERTEX_A = 'd0;
  localparam logic [APB_AW-4:0] REG_VERTEX_B = 'd1;
  localparam logic [APB_AW-4:0] REG_VERTEX_C = 'd2;
  localparam logic [APB_AW-4:0] REG_DET_THR  = 'd3;
  localparam logic [APB_AW-4:0] REG_CLIP     = 'd4;

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [DIF_W-1:0]      dif_t;
  typedef logic signed [PRD_W-1:0]      prd_t;
  typedef logic signed [CRS_W-1:0]      crs_t;
  typedef logic signed [DPR_W-1:0]      dpr_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [SUM_W:0]        uv_t;

  typedef struct packed {
    crd_t x;
    crd_t y;
    crd_t z;
  } cvec_t;

  typedef struct packed {
    dif_t x;
    dif_t y;
    dif_t z;
  } dvec_t;

  typedef struct packed {
    crs_t x;
    crs_t y;
    crs_t z;
  } xvec_t;

  typedef struct packed {
    cvec_t start_pt;
    cvec_t end_pt;
  } ray_t;

  // Triangle setup as seen by the datapath.
  typedef struct packed {
    cvec_t            va;
    dvec_t            e1;   // a to c
    dvec_t            e2;   // a to b
    logic [THR_W-1:0] thr;
    logic             clip;
  } tri_t;

  // Cross stage output: ray terms plus P = D x e2 and Q = T x e1.
  typedef struct packed {
    logic  valid;
    dvec_t dir;
    dvec_t tv;
    xvec_t p;
    xvec_t q;
  } crs_stage_t;

  typedef struct packed {
    logic valid;
    sum_t det;
    sum_t u;
    sum_t v;
    sum_t n;
  } dot_stage_t;

  function automatic cvec_t unpack_vtx(input logic [VTX_W-1:0] w);
    cvec_t r;
    r.x = crd_t'(w[3*COORD_BITS-1:2*COORD_BITS]);
    r.y = crd_t'(w[2*COORD_BITS-1:COORD_BITS]);
    r.z = crd_t'(w[COORD_BITS-1:0]);
    return r;
  endfunction

  function automatic dvec_t vsub(input cvec_t a, input cvec_t b);
    dvec_t r;
    r.x = dif_t'(a.x) - dif_t'(b.x);
    r.y = dif_t'(a.y) - dif_t'(b.y);
    r.z = dif_t'(a.z) - dif_t'(b.z);
    return r;
  endfunction

  function automatic prd_t mul_dd(input dif_t a, input dif_t b);
    return prd_t'(a) * prd_t'(b);
  endfunction

  function automatic dpr_t mul_dx(input dif_t a, input crs_t b);
    return dpr_t'(a) * dpr_t'(b);
  endfunction

endpackage

// ===== rtl/rth_if.sv =====
interface rth_ray_if;
  import rth_pkg::*;

  logic valid;
  logic ready;
  crd_t start_x;
  crd_t start_y;
  crd_t start_z;
  crd_t end_x;
  crd_t end_y;
  crd_t end_z;

  modport source (output valid, output start_x, output start_y, output start_z,
                  output end_x, output end_y, output end_z, input ready);
  modport sink   (input valid, input start_x, input start_y, input start_z,
                  input end_x, input end_y, input end_z, output ready);
endinterface

interface rth_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink   (input valid, input hit, output ready);
endinterface

// ===== rtl/rth_regs.sv =====
module rth_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rth_pkg::APB_AW-1:0]     paddr,
  input  logic [rth_pkg::APB_DW-1:0]     pwdata,
  output logic [rth_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  output rth_pkg::tri_t                  tri_o
);
  import rth_pkg::*;

  logic [VTX_W-1:0]  vtx_a_q, vtx_b_q, vtx_c_q;
  logic [THR_W-1:0]  thr_q;
  logic              clip_q;
  logic [APB_AW-4:0] idx;
  logic              wr_en;
  cvec_t             va, vb, vc;

  assign idx   = paddr[APB_AW-1:3];
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_a_q <= '0;
      vtx_b_q <= '0;
      vtx_c_q <= '0;
      thr_q   <= DET_THR_RST;
      clip_q  <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_VERTEX_A: vtx_a_q <= pwdata[VTX_W-1:0];
        REG_VERTEX_B: vtx_b_q <= pwdata[VTX_W-1:0];
        REG_VERTEX_C: vtx_c_q <= pwdata[VTX_W-1:0];
        REG_DET_THR:  thr_q   <= pwdata[THR_W-1:0];
        REG_CLIP:     clip_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VERTEX_A: prdata = APB_DW'(vtx_a_q);
      REG_VERTEX_B: prdata = APB_DW'(vtx_b_q);
      REG_VERTEX_C: prdata = APB_DW'(vtx_c_q);
      REG_DET_THR:  prdata = APB_DW'(thr_q);
      REG_CLIP:     prdata = APB_DW'(clip_q);
      default:      prdata = '0;
    endcase
  end

  // Edges are static between writes, so they are formed straight off the registers.
  assign va = unpack_vtx(vtx_a_q);
  assign vb = unpack_vtx(vtx_b_q);
  assign vc = unpack_vtx(vtx_c_q);

  assign tri_o.va   = va;
  assign tri_o.e1   = vsub(vc, va);
  assign tri_o.e2   = vsub(vb, va);
  assign tri_o.thr  = thr_q;
  assign tri_o.clip = clip_q;

endmodule

// ===== rtl/rth_cross.sv =====
module rth_cross (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  rth_pkg::ray_t        ray_i,
  input  rth_pkg::tri_t        tri_i,
  output rth_pkg::crs_stage_t  crs_o
);
  import rth_pkg::*;

  // stage 1: differences
  logic  s1_valid_q;
  dvec_t s1_dir_q, s1_t_q;
  // stage 2: twelve partial products
  logic  s2_valid_q;
  dvec_t s2_dir_q, s2_t_q;
  prd_t  px0_q, px1_q, py0_q, py1_q, pz0_q, pz1_q;
  prd_t  qx0_q, qx1_q, qy0_q, qy1_q, qz0_q, qz1_q;
  // stage 3: cross products
  logic  s3_valid_q;
  dvec_t s3_dir_q, s3_t_q;
  xvec_t s3_p_q, s3_q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_dir_q <= vsub(ray_i.end_pt, ray_i.start_pt);
      s1_t_q   <= vsub(ray_i.start_pt, tri_i.va);

      s2_dir_q <= s1_dir_q;
      s2_t_q   <= s1_t_q;
      // P = D x e2
      px0_q <= mul_dd(s1_dir_q.y, tri_i.e2.z);
      px1_q <= mul_dd(s1_dir_q.z, tri_i.e2.y);
      py0_q <= mul_dd(s1_dir_q.z, tri_i.e2.x);
      py1_q <= mul_dd(s1_dir_q.x, tri_i.e2.z);
      pz0_q <= mul_dd(s1_dir_q.x, tri_i.e2.y);
      pz1_q <= mul_dd(s1_dir_q.y, tri_i.e2.x);
      // Q = T x e1
      qx0_q <= mul_dd(s1_t_q.y, tri_i.e1.z);
      qx1_q <= mul_dd(s1_t_q.z, tri_i.e1.y);
      qy0_q <= mul_dd(s1_t_q.z, tri_i.e1.x);
      qy1_q <= mul_dd(s1_t_q.x, tri_i.e1.z);
      qz0_q <= mul_dd(s1_t_q.x, tri_i.e1.y);
      qz1_q <= mul_dd(s1_t_q.y, tri_i.e1.x);

      s3_dir_q <= s2_dir_q;
      s3_t_q   <= s2_t_q;
      s3_p_q.x <= crs_t'(px0_q) - crs_t'(px1_q);
      s3_p_q.y <= crs_t'(py0_q) - crs_t'(py1_q);
      s3_p_q.z <= crs_t'(pz0_q) - crs_t'(pz1_q);
      s3_q_q.x <= crs_t'(qx0_q) - crs_t'(qx1_q);
      s3_q_q.y <= crs_t'(qy0_q) - crs_t'(qy1_q);
      s3_q_q.z <= crs_t'(qz0_q) - crs_t'(qz1_q);
    end
  end

  assign crs_o.valid = s3_valid_q;
  assign crs_o.dir   = s3_dir_q;
  assign crs_o.tv    = s3_t_q;
  assign crs_o.p     = s3_p_q;
  assign crs_o.q     = s3_q_q;

endmodule

// ===== rtl/rth_dot.sv =====
module rth_dot (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  rth_pkg::crs_stage_t  crs_i,
  input  rth_pkg::tri_t        tri_i,
  output rth_pkg::dot_stage_t  dot_o
);
  import rth_pkg::*;

  // stage 4: products, stage 5: three-term sums
  logic s4_valid_q, s5_valid_q;
  dpr_t d0_q, d1_q, d2_q;   // det = e1 . P
  dpr_t u0_q, u1_q, u2_q;   // u   = T  . P
  dpr_t v0_q, v1_q, v2_q;   // v   = D  . Q
  dpr_t n0_q, n1_q, n2_q;   // n   = e2 . Q
  sum_t det_q, u_q, v_q, n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (adv_i) begin
      s4_valid_q <= crs_i.valid;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d0_q <= mul_dx(tri_i.e1.x, crs_i.p.x);
      d1_q <= mul_dx(tri_i.e1.y, crs_i.p.y);
      d2_q <= mul_dx(tri_i.e1.z, crs_i.p.z);
      u0_q <= mul_dx(crs_i.tv.x, crs_i.p.x);
      u1_q <= mul_dx(crs_i.tv.y, crs_i.p.y);
      u2_q <= mul_dx(crs_i.tv.z, crs_i.p.z);
      v0_q <= mul_dx(crs_i.dir.x, crs_i.q.x);
      v1_q <= mul_dx(crs_i.dir.y, crs_i.q.y);
      v2_q <= mul_dx(crs_i.dir.z, crs_i.q.z);
      n0_q <= mul_dx(tri_i.e2.x, crs_i.q.x);
      n1_q <= mul_dx(tri_i.e2.y, crs_i.q.y);
      n2_q <= mul_dx(tri_i.e2.z, crs_i.q.z);

      det_q <= sum_t'(d0_q) + sum_t'(d1_q) + sum_t'(d2_q);
      u_q   <= sum_t'(u0_q) + sum_t'(u1_q) + sum_t'(u2_q);
      v_q   <= sum_t'(v0_q) + sum_t'(v1_q) + sum_t'(v2_q);
      n_q   <= sum_t'(n0_q) + sum_t'(n1_q) + sum_t'(n2_q);
    end
  end

  assign dot_o.valid = s5_valid_q;
  assign dot_o.det   = det_q;
  assign dot_o.u     = u_q;
  assign dot_o.v     = v_q;
  assign dot_o.n     = n_q;

endmodule

// ===== rtl/rth_decide.sv =====
module rth_decide (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rth_pkg::dot_stage_t  dot_i,
  input  rth_pkg::tri_t        tri_i,
  output logic                 adv_o,
  rth_hit_if.source            hit_o
);
  import rth_pkg::*;

  logic out_valid_q, out_valid_d, out_hit_q, out_hit_d;
  logic skid_valid_q, skid_valid_d, skid_hit_q, skid_hit_d;
  logic push, pop, hit_now;
  sum_t thr_ext;
  uv_t  uv_sum, det_ext;

  assign thr_ext = sum_t'($signed({1'b0, tri_i.thr}));
  assign uv_sum  = uv_t'(dot_i.u) + uv_t'(dot_i.v);
  assign det_ext = uv_t'(dot_i.det);

  always_comb begin
    hit_now = 1'b1;
    if (dot_i.det < thr_ext)                  hit_now = 1'b0;
    if (dot_i.u[SUM_W-1])                     hit_now = 1'b0;
    if (dot_i.det < dot_i.u)                  hit_now = 1'b0;
    if (dot_i.v[SUM_W-1])                     hit_now = 1'b0;
    if (det_ext < uv_sum)                     hit_now = 1'b0;
    if (dot_i.n[SUM_W-1])                     hit_now = 1'b0;
    if (tri_i.clip && (dot_i.det < dot_i.n))  hit_now = 1'b0;
  end

  // Pipe moves whenever the skid slot is free; the output word or the skid
  // slot can then always absorb what leaves the last stage.
  assign adv_o = ~skid_valid_q;
  assign push  = dot_i.valid & adv_o;
  assign pop   = out_valid_q & hit_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_hit_d    = out_hit_q;
    skid_valid_d = skid_valid_q;
    skid_hit_d   = skid_hit_q;
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_hit_d    = skid_hit_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_hit_d   = hit_now;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_hit_d   = hit_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q  <= out_hit_d;
    skid_hit_q <= skid_hit_d;
  end

  assign hit_o.valid = out_valid_q;
  assign hit_o.hit   = out_hit_q;

endmodule

// ===== rtl/ray_triangle_hit_test.sv =====
// Ray/triangle hit test, back faces culled (Moller-Trumbore). Each input
// word carries a ray as start and end points in signed Q4.12; each output
// word carries one hit bit, in input order. The triangle (vertices a, b, c;
// edge one a->c, edge two a->b), the determinant threshold (Q.36, reset
// 0.00001) and the clip flag (also require the hit parameter <= 1) sit in
// APB registers at byte offsets 0, 8, 16, 24, 32; write them only while no
// ray is in flight. All arithmetic is exact, no rounding and no division:
// a hit needs det >= threshold, 0 <= u <= det, v >= 0, u + v <= det and
// n >= 0 (n <= det with clipping). Throughput is one ray per clock unless
// the output stalls. From input accept to output valid: three stages for
// the edge differences and the two cross products, two for the four dot
// products, and the output register, where the compares land. A two-entry
// output buffer lets the input keep flowing while a result waits; its
// ready is registered, so the input ready never depends on output ready.
module ray_triangle_hit_test (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rth_pkg::APB_AW-1:0]  paddr,
  input  logic [rth_pkg::APB_DW-1:0]  pwdata,
  output logic [rth_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  rth_ray_if.sink                     ray_i,
  rth_hit_if.source                   hit_o
);
  import rth_pkg::*;

  tri_t       tri_cfg;
  ray_t       ray;
  crs_stage_t crs;
  dot_stage_t dot;
  logic       adv;

  rth_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tri_o   (tri_cfg)
  );

  assign ray.start_pt.x = ray_i.start_x;
  assign ray.start_pt.y = ray_i.start_y;
  assign ray.start_pt.z = ray_i.start_z;
  assign ray.end_pt.x   = ray_i.end_x;
  assign ray.end_pt.y   = ray_i.end_y;
  assign ray.end_pt.z   = ray_i.end_z;

  // whole pipe stalls together; a word is taken whenever it moves
  assign ray_i.ready = adv;

  rth_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (ray_i.valid),
    .ray_i   (ray),
    .tri_i   (tri_cfg),
    .crs_o   (crs)
  );

  rth_dot u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .crs_i  (crs),
    .tri_i  (tri_cfg),
    .dot_o  (dot)
  );

  rth_decide u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dot_i  (dot),
    .tri_i  (tri_cfg),
    .adv_o  (adv),
    .hit_o  (hit_o)
  );

endmodule

// ===== rtl/rth_checker.sv =====
module rth_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_hit_i
);
  import rth_pkg::*;

  localparam int CAP   = PIPE_DEPTH + 2;
  localparam int CNT_W = $clog2(CAP + 2);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i & in_ready_i;
  assign out_acc = out_valid_i & out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) cnt_d = cnt_q + CNT_W'(1);
    if (!in_acc && out_acc) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  // no result without a word in flight
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result word with no ray in flight");

  // in-flight words never exceed pipe plus output buffer
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAP))
    else $error("more words in flight than the pipe holds");

  // an empty block always takes a ray
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> in_ready_i)
    else $error("idle block refuses input");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_hit_i))
    else $error("stalled result word changed");

endmodule

bind ray_triangle_hit_test rth_checker u_rth_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (ray_i.valid),
  .in_ready_i  (ray_i.ready),
  .out_valid_i (hit_o.valid),
  .out_ready_i (hit_o.ready),
  .out_hit_i   (hit_o.hit)
);
